// ----- rtl/rar_pkg.sv -----
`default_nettype none

package rar_pkg;

  // Default operand size; operands are masked to this many bits
  localparam int OPERAND_BITS_DEF = 16;

  // Fixed field widths of the transactions
  localparam int MODE_W = 2;
  localparam int IN_W   = 16;
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 32;
  localparam int FORM_W = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 2'd3;

  // Result form codes
  localparam logic [FORM_W-1:0] FORM_INT    = 2'd0;
  localparam logic [FORM_W-1:0] FORM_MIXED  = 2'd1;
  localparam logic [FORM_W-1:0] FORM_PROPER = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/rational_arith_reduce_top.sv -----
`default_nettype none

// Fraction arithmetic with reduction to lowest terms. One transaction takes
// a_num/a_den and b_num/b_den and an operation (add, subtract, multiply,
// divide) and returns the reduced numerator and denominator, the whole part,
// the remainder and a form code. A fraction with a zero numerator or zero
// denominator counts as zero, but in subtract a zero denominator makes the
// result zero; a zero result is returned as all-zero fields. Items are
// handled one at a time: in_ready is high only while the sequencer is idle,
// and a finished result sits in an output register so the next item can be
// taken while it waits. With NW = 2*min(OPERAND_BITS,16)+1 (33 at the
// default), an item passes through four products in the shared multiplier,
// a combine step, a binary GCD and three restoring divisions (numerator by
// gcd, denominator by gcd, numerator by denominator); the GCD and the
// divisions share one subtract/compare unit. A zero result skips the GCD
// and the divisions. The GCD step count depends on the operand values.
module rational_arith_reduce_top #(
  parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rar_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [rar_pkg::IN_W-1:0]    in_a_num,
  input  wire logic [rar_pkg::IN_W-1:0]    in_a_den,
  input  wire logic [rar_pkg::IN_W-1:0]    in_b_num,
  input  wire logic [rar_pkg::IN_W-1:0]    in_b_den,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [rar_pkg::NUM_W-1:0] out_res_num,
  output logic [rar_pkg::DEN_W-1:0]        out_res_den,
  output logic signed [rar_pkg::NUM_W-1:0] out_whole_part,
  output logic [rar_pkg::DEN_W-1:0]        out_frac_rem,
  output logic [rar_pkg::FORM_W-1:0]       out_form
);
  import rar_pkg::*;

  // Effective operand width, product width, unreduced numerator width
  localparam int W  = (OPERAND_BITS < IN_W) ? OPERAND_BITS : IN_W;
  localparam int PW = 2 * W;
  localparam int NW = PW + 1;
  localparam int CW = $clog2(NW);
  localparam int KW = $clog2(NW + 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DIVW, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Operand and intermediate registers
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [W-1:0]      an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [1:0]        mcnt_r, mcnt_nxt;
  logic [PW-1:0]     pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt, pd_r, pd_nxt;
  logic [NW-1:0]     n_r, n_nxt, d_r, d_nxt;
  logic              neg_r, neg_nxt, zero_r, zero_nxt;
  logic [NW-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [NW-1:0]     rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [NUM_W-1:0] num_o_r, num_o_nxt, whole_o_r, whole_o_nxt;
  logic [DEN_W-1:0]        den_o_r, den_o_nxt, rem_o_r, rem_o_nxt;
  logic [FORM_W-1:0]       form_o_r, form_o_nxt;

  // Shared multiplier: one product per cycle
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;

  always_comb begin
    case (mcnt_r)
      2'd0:    begin mul_a = an_r; mul_b = bd_r; end
      2'd1:    begin mul_a = ad_r; mul_b = bn_r; end
      2'd2:    begin mul_a = ad_r; mul_b = bd_r; end
      default: begin mul_a = an_r; mul_b = bn_r; end
    endcase
  end

  assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  // Shared subtract/compare unit: GCD steps and restoring division steps
  logic [NW:0]   sub_a, sub_b;
  logic [NW+1:0] sub_diff;
  logic          sub_borrow;

  always_comb begin
    if (state_r == S_GCD) begin
      sub_a = {1'b0, x_r};
      sub_b = {1'b0, y_r};
    end else begin
      sub_a = {rem_r, quo_r[NW-1]};
      sub_b = {1'b0, dvs_r};
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[NW+1];

  // One restoring division step
  logic [NW-1:0] div_rem, div_quo;
  assign div_rem = sub_borrow ? sub_a[NW-1:0] : sub_diff[NW-1:0];
  assign div_quo = {quo_r[NW-2:0], ~sub_borrow};

  // Cross-product combination per operation, with the zero-operand rules
  logic          za, zb, cneg;
  logic [NW-1:0] cn, cd;

  always_comb begin
    za   = (an_r == '0) || (ad_r == '0);
    zb   = (bn_r == '0) || (bd_r == '0);
    cneg = 1'b0;
    cn   = '0;
    cd   = '0;
    case (mode_r)
      MODE_ADD: begin
        if (za) begin
          cn = NW'(bn_r);
          cd = NW'(bd_r);
        end else if (zb) begin
          cn = NW'(an_r);
          cd = NW'(ad_r);
        end else begin
          cn = NW'(pa_r) + NW'(pb_r);
          cd = NW'(pc_r);
        end
      end
      MODE_SUB: begin
        cneg = pa_r < pb_r;
        cn   = cneg ? NW'(pb_r - pa_r) : NW'(pa_r - pb_r);
        cd   = NW'(pc_r);
      end
      MODE_MUL: begin
        if (!za && !zb) begin
          cn = NW'(pd_r);
          cd = NW'(pc_r);
        end
      end
      default: begin
        if (!za && !zb) begin
          cn = NW'(pa_r);
          cd = NW'(pb_r);
        end
      end
    endcase
  end

  // Output formatting from the reduced fraction
  logic [NUM_W-1:0]  fmt_num, fmt_whole;
  logic [FORM_W-1:0] fmt_form;

  always_comb begin
    fmt_num   = NUM_W'(n_r);
    fmt_whole = NUM_W'(quo_r);
    if (neg_r) begin
      fmt_num = NUM_W'(0) - fmt_num;
      if (quo_r != '0) begin
        fmt_whole = NUM_W'(0) - fmt_whole;
      end
    end
    if (d_r == NW'(1)) begin
      fmt_form = FORM_INT;
    end else if (n_r > d_r) begin
      fmt_form = FORM_MIXED;
    end else begin
      fmt_form = FORM_PROPER;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    mcnt_nxt      = mcnt_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    pc_nxt        = pc_r;
    pd_nxt        = pd_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    num_o_nxt     = num_o_r;
    den_o_nxt     = den_o_r;
    whole_o_nxt   = whole_o_r;
    rem_o_nxt     = rem_o_r;
    form_o_nxt    = form_o_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          an_nxt    = in_a_num[W-1:0];
          ad_nxt    = in_a_den[W-1:0];
          bn_nxt    = in_b_num[W-1:0];
          bd_nxt    = in_b_den[W-1:0];
          mcnt_nxt  = '0;
          state_nxt = S_MUL;
        end
      end

      // four products, one per cycle
      S_MUL: begin
        case (mcnt_r)
          2'd0:    pa_nxt = prod;
          2'd1:    pb_nxt = prod;
          2'd2:    pc_nxt = prod;
          default: pd_nxt = prod;
        endcase
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          state_nxt = S_COMB;
        end
      end

      S_COMB: begin
        n_nxt    = cn;
        d_nxt    = cd;
        neg_nxt  = cneg;
        x_nxt    = cn;
        y_nxt    = cd;
        k_nxt    = '0;
        zero_nxt = (cn == '0) || (cd == '0);
        state_nxt = ((cn == '0) || (cd == '0)) ? S_FIN : S_GCD;
      end

      // binary GCD: one shift or compare/subtract per cycle
      S_GCD: begin
        if ((x_r == '0) || (y_r == '0)) begin
          dvs_nxt   = (x_r | y_r) << k_r;
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (!sub_borrow) begin
          x_nxt = sub_diff[NW-1:0];
        end else begin
          // swap so the larger value is subtracted from next
          x_nxt = y_r;
          y_nxt = x_r;
        end
      end

      // numerator / gcd
      S_DIVN: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          n_nxt     = div_quo;
          rem_nxt   = '0;
          quo_nxt   = d_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end
      end

      // denominator / gcd
      S_DIVD: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          d_nxt     = div_quo;
          dvs_nxt   = div_quo;
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVW;
        end
      end

      // whole part and remainder, left in quo_r and rem_r
      S_DIVW: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FIN;
        end
      end

      // hand over to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            num_o_nxt   = '0;
            den_o_nxt   = '0;
            whole_o_nxt = '0;
            rem_o_nxt   = '0;
            form_o_nxt  = FORM_INT;
          end else begin
            num_o_nxt   = fmt_num;
            den_o_nxt   = DEN_W'(d_r);
            whole_o_nxt = fmt_whole;
            rem_o_nxt   = DEN_W'(rem_r);
            form_o_nxt  = fmt_form;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r    <= mode_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    mcnt_r    <= mcnt_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    pc_r      <= pc_nxt;
    pd_r      <= pd_nxt;
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    neg_r     <= neg_nxt;
    zero_r    <= zero_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    k_r       <= k_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    cnt_r     <= cnt_nxt;
    num_o_r   <= num_o_nxt;
    den_o_r   <= den_o_nxt;
    whole_o_r <= whole_o_nxt;
    rem_o_r   <= rem_o_nxt;
    form_o_r  <= form_o_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_res_num    = num_o_r;
  assign out_res_den    = den_o_r;
  assign out_whole_part = whole_o_r;
  assign out_frac_rem   = rem_o_r;
  assign out_form       = form_o_r;

endmodule

`default_nettype wire
